FILE: rtl/n2wf_pkg.sv
// shared types and constants of the normalised window filter
package n2wf_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 2;
  localparam int KSZ_W      = 3;
  localparam int COEF_W     = 8;
  localparam int PIX_W      = 8;
  localparam int RES_W      = 21;
  localparam int POS_W      = 10;

  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KSIZE  = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam logic [KSZ_W-1:0] KSIZE_RESET  = 3'd3;

  localparam logic MODE_COEF  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [2:0]               coef_row;
    logic [2:0]               coef_col;
    logic signed [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]         pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    divide_error;
    logic                    last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic take_item;
    logic coef_upd;
    logic win_shift;
    logic mac_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic produce;
    logic mac_done;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/normalized_2d_window_filter.sv
// top level of the normalised two-dimensional window filter
//
//   port group  direction  handshake           payload
//   in_         in         in_valid/in_stall   n2wf_pkg::in_item_t
//   out_        out        out_valid/out_stall n2wf_pkg::out_item_t
//   cfg_        in         cfg_we              cfg_addr, cfg_wdata
//
// a coefficient or a pixel without a result passes the take and decode states; a
// pixel with a result then also passes the mac, the serial divider and the
// output load, all through the one shared multiplier and divider
// synchronous active-low reset; no clearing pass, line buffers are not reset
// one transaction is worked on at a time; in_stall is high while it is busy
// the output register lets the next transaction in while a result waits
module normalized_2d_window_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  n2wf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output n2wf_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [n2wf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [n2wf_pkg::CFG_W-1:0]      cfg_wdata
);

  n2wf_pkg::cmd_t cmd;
  n2wf_pkg::sts_t sts;

  n2wf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  n2wf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/n2wf_ram.sv
// generic single write port ram with registered read
module n2wf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/n2wf_ctrl.sv
// sequencing state machine of the normalised window filter
module n2wf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  n2wf_pkg::sts_t sts,
  output n2wf_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MAC    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_pixel) begin
          cmd.win_shift = 1'b1;
          state_nxt     = sts.produce ? S_MAC : S_IDLE;
        end else begin
          cmd.coef_upd = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (sts.mac_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/n2wf_dp.sv
// datapath: settings, line buffers, window, kernel, mac and serial divider
module n2wf_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  n2wf_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [n2wf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [n2wf_pkg::CFG_W-1:0]          cfg_wdata,
  input  n2wf_pkg::cmd_t                      cmd,
  output n2wf_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output n2wf_pkg::out_item_t                 out_data
);

  localparam int NCELL  = MAX_KERNEL * MAX_KERNEL;
  localparam int KIDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
  localparam int K_W    = $clog2(MAX_KERNEL + 1);
  localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int PROD_W = 16;
  localparam int MAC_W  = PROD_W + $clog2(NCELL);
  localparam int KSUM_W = n2wf_pkg::COEF_W + $clog2(NCELL);
  localparam int DCNT_W = $clog2(MAC_W + 1);
  localparam int PIX_W  = n2wf_pkg::PIX_W;
  localparam int RES_W  = n2wf_pkg::RES_W;
  localparam int POS_W  = n2wf_pkg::POS_W;

  // settings
  logic [n2wf_pkg::CFG_W-1:0] width_r, height_r;
  logic [n2wf_pkg::KSZ_W-1:0] ksize_r;
  logic [WEFF_W-1:0]          w_eff;
  logic [HEFF_W-1:0]          h_eff;
  logic [K_W-1:0]             k_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HEFF_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(height_r);
    end
    if (ksize_r == '0) begin
      k_eff = K_W'(1);
    end else if (32'(ksize_r) > MAX_KERNEL) begin
      k_eff = K_W'(MAX_KERNEL);
    end else begin
      k_eff = K_W'(ksize_r);
    end
  end

  // raster position and line buffer slot of the current row
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SLOT_W-1:0] slot_r;

  // latched transaction and what it needs later
  n2wf_pkg::in_item_t item_r;
  logic [ROW_W-1:0]   row_l_r;
  logic [SLOT_W-1:0]  slot_l_r;
  logic               produce_r;
  logic [POS_W-1:0]   res_row_r, res_col_r;
  logic               last_r;

  logic in_pix;
  logic col_end, row_end;
  assign in_pix  = (in_data.mode == n2wf_pkg::MODE_PIXEL);
  assign col_end = (32'(col_r) + 1 == 32'(w_eff));
  assign row_end = (32'(row_r) + 1 == 32'(h_eff));

  // kernel store
  logic signed [n2wf_pkg::COEF_W-1:0] kern_r [NCELL];
  logic signed [KSUM_W-1:0]           ksum_r;
  logic [KIDX_W-1:0]                  coef_idx, kaddr;
  logic signed [n2wf_pkg::COEF_W-1:0] kern_rd;
  logic                               coef_in;

  // window and mac
  logic [PIX_W-1:0]         win_r [NCELL];
  logic [PIX_W-1:0]         win_nxt [NCELL];
  logic [PIX_W-1:0]         newcol [MAX_KERNEL];
  logic [PIX_W-1:0]         rd [MAX_KERNEL];
  logic [KIDX_W-1:0]        idx_r;
  logic [K_W-1:0]           mc_r;
  logic                     fin_r, prod_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MAC_W-1:0]  acc_r;

  // divider
  logic [MAC_W-1:0]        a_r;
  logic [KSUM_W-1:0]       rem_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic                    neg_r, err_r;
  logic [MAC_W-1:0]        acc_abs;
  logic [KSUM_W-1:0]       dabs;
  logic [KSUM_W:0]         trial;
  logic signed [MAC_W:0]   qs;

  n2wf_pkg::out_item_t out_r;
  logic                out_valid_r;

  assign coef_idx = KIDX_W'(32'(item_r.coef_row) * MAX_KERNEL + 32'(item_r.coef_col));
  assign coef_in  = (32'(item_r.coef_row) < 32'(k_eff)) && (32'(item_r.coef_col) < 32'(k_eff));
  assign kaddr    = cmd.coef_upd ? coef_idx : idx_r;
  assign kern_rd  = kern_r[kaddr];

  // one line buffer per kernel row slot, all read at the incoming column
  for (genvar s = 0; s < MAX_KERNEL; s++) begin : g_line
    n2wf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (cmd.take_item && in_pix && (slot_r == SLOT_W'(s))),
      .waddr (col_r),
      .wdata (in_data.pixel_value),
      .raddr (col_r),
      .rdata (rd[s])
    );
  end

  // newest window column: line buffer rows above, incoming pixel at the bottom
  always_comb begin
    int t;
    t = 0;
    for (int r = 0; r < MAX_KERNEL; r++) begin
      t = 32'(slot_l_r) + MAX_KERNEL + 1 + r - 32'(k_eff);
      if (t >= MAX_KERNEL) begin
        t = t - MAX_KERNEL;
      end
      if (r + 1 == 32'(k_eff)) begin
        newcol[r] = item_r.pixel_value;
      end else if (32'(row_l_r) + 1 + r >= 32'(k_eff)) begin
        newcol[r] = rd[SLOT_W'(t)];
      end else begin
        newcol[r] = '0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      for (int c = 0; c < MAX_KERNEL; c++) begin
        if (r >= 32'(k_eff)) begin
          win_nxt[r*MAX_KERNEL+c] = win_r[r*MAX_KERNEL+c];
        end else if (c + 1 == 32'(k_eff)) begin
          win_nxt[r*MAX_KERNEL+c] = newcol[r];
        end else if (c + 1 < MAX_KERNEL) begin
          win_nxt[r*MAX_KERNEL+c] = win_r[r*MAX_KERNEL+c+1];
        end else begin
          win_nxt[r*MAX_KERNEL+c] = win_r[r*MAX_KERNEL+c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      win_r <= win_nxt;
    end
  end

  assign acc_abs = acc_r[MAC_W-1] ? MAC_W'(-acc_r) : MAC_W'(acc_r);
  assign dabs    = ksum_r[KSUM_W-1] ? KSUM_W'(-ksum_r) : KSUM_W'(ksum_r);
  assign trial   = {rem_r, a_r[MAC_W-1]};
  assign qs      = neg_r ? -$signed({1'b0, a_r}) : $signed({1'b0, a_r});

  // control state: settings, position, kernel, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= n2wf_pkg::WIDTH_RESET;
      height_r    <= n2wf_pkg::HEIGHT_RESET;
      ksize_r     <= n2wf_pkg::KSIZE_RESET;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      ksum_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCELL; i++) begin
        kern_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          n2wf_pkg::REG_WIDTH: begin
            width_r <= cfg_wdata;
            col_r   <= '0;
            row_r   <= '0;
            slot_r  <= '0;
          end
          n2wf_pkg::REG_HEIGHT: begin
            height_r <= cfg_wdata;
            col_r    <= '0;
            row_r    <= '0;
            slot_r   <= '0;
          end
          n2wf_pkg::REG_KSIZE: begin
            ksize_r <= cfg_wdata[n2wf_pkg::KSZ_W-1:0];
            col_r   <= '0;
            row_r   <= '0;
            slot_r  <= '0;
            ksum_r  <= '0;
            for (int i = 0; i < NCELL; i++) begin
              kern_r[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.take_item && in_pix) begin
        if (col_end) begin
          col_r <= '0;
          if (row_end) begin
            row_r  <= '0;
            slot_r <= '0;
          end else begin
            row_r  <= row_r + ROW_W'(1);
            slot_r <= (32'(slot_r) + 1 == MAX_KERNEL) ? '0 : slot_r + SLOT_W'(1);
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (cmd.coef_upd && coef_in) begin
        kern_r[coef_idx] <= item_r.coef_value;
        ksum_r <= ksum_r - KSUM_W'(kern_rd) + KSUM_W'(item_r.coef_value);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction latch, mac and divider
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r    <= in_data;
      row_l_r   <= row_r;
      slot_l_r  <= slot_r;
      produce_r <= in_pix && (32'(row_r) + 1 >= 32'(k_eff)) && (32'(col_r) + 1 >= 32'(k_eff));
      res_row_r <= POS_W'(32'(row_r) + 1 - 32'(k_eff));
      res_col_r <= POS_W'(32'(col_r) + 1 - 32'(k_eff));
      last_r    <= col_end && row_end;
    end
    if (cmd.win_shift) begin
      idx_r    <= '0;
      mc_r     <= '0;
      fin_r    <= 1'b0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else if (cmd.mac_step) begin
      if (!fin_r) begin
        prod_r   <= PROD_W'($signed({1'b0, win_r[idx_r]}) * kern_rd);
        prod_v_r <= 1'b1;
        if (mc_r + K_W'(1) == k_eff) begin
          mc_r  <= '0;
          idx_r <= KIDX_W'(32'(idx_r) + MAX_KERNEL + 1 - 32'(k_eff));
          if (32'(idx_r) == (32'(k_eff) - 1) * (MAX_KERNEL + 1)) begin
            fin_r <= 1'b1;
          end
        end else begin
          mc_r  <= mc_r + K_W'(1);
          idx_r <= idx_r + KIDX_W'(1);
        end
      end else begin
        prod_v_r <= 1'b0;
      end
      if (prod_v_r) begin
        acc_r <= acc_r + MAC_W'(prod_r);
      end
    end
    if (cmd.div_init) begin
      a_r    <= acc_abs;
      rem_r  <= '0;
      dcnt_r <= '0;
      neg_r  <= acc_r[MAC_W-1] ^ ksum_r[KSUM_W-1];
      err_r  <= (ksum_r == '0);
    end else if (cmd.div_step) begin
      // restoring step: one quotient bit per cycle
      if (trial >= {1'b0, dabs}) begin
        rem_r <= KSUM_W'(trial - {1'b0, dabs});
        a_r   <= {a_r[MAC_W-2:0], 1'b1};
      end else begin
        rem_r <= KSUM_W'(trial);
        a_r   <= {a_r[MAC_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r.result_value  <= err_r ? '0 : RES_W'(qs);
      out_r.out_row       <= res_row_r;
      out_r.out_col       <= res_col_r;
      out_r.divide_error  <= err_r;
      out_r.last_of_frame <= last_r;
    end
  end

  assign sts.is_pixel = (item_r.mode == n2wf_pkg::MODE_PIXEL);
  assign sts.produce  = produce_r;
  assign sts.mac_done = fin_r && !prod_v_r;
  assign sts.div_last = (32'(dcnt_r) == MAC_W - 1);
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
